/* hw/rtl/qpsk_pkg.sv */
// Package for the QPSK carrier generator: widths, register indexes,
// the link structs between units, and the symbol and sine lookup functions.
// No dependencies.
package qpsk_pkg;

  localparam int unsigned PhasePoints = 72;
  localparam int unsigned HalfPoints  = PhasePoints / 2;
  localparam int unsigned QuarterPoints = PhasePoints / 4;

  localparam int unsigned PhaseW  = 7;
  localparam int unsigned OffsetW = 6;
  localparam int unsigned CountW  = 6;
  localparam int unsigned SampleW = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 7;

  localparam logic [CfgIdxW-1:0] CFG_SAMPLES_PER_SYMBOL = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PHASE_STEP         = 2'd1;

  localparam logic [CountW-1:0] SPR_RESET  = 6'd30;
  localparam logic [PhaseW-1:0] STEP_RESET = 7'd4;

  localparam logic [PhaseW-1:0] PHASE_POINTS_V = 7'(PhasePoints);
  localparam logic [PhaseW-1:0] HALF_POINTS_V  = 7'(HalfPoints);
  localparam logic [PhaseW-1:0] QUARTER_POINTS_V = 7'(QuarterPoints);

  // Symbol handed from the input queue to the sample generator.
  typedef struct packed {
    logic               valid;
    logic [OffsetW-1:0] offset;
  } qpsk_sym_t;

  // One result beat handed from the generator to the output queue.
  typedef struct packed {
    logic               valid;
    logic [SampleW-1:0] sample;
    logic               last;
  } qpsk_beat_t;

  // Phase offset in 1/72 of a carrier period for each symbol.
  function automatic logic [OffsetW-1:0] symbol_offset(input logic [1:0] sym);
    logic [OffsetW-1:0] off;
    case (sym)
      2'd0:    off = 6'd27;
      2'd1:    off = 6'd9;
      2'd2:    off = 6'd45;
      2'd3:    off = 6'd63;
      default: off = 6'd27;
    endcase
    return off;
  endfunction

  // round(0x7F000000 * sin(k * 5 degrees)) for k = 0..18.
  function automatic logic [SampleW-1:0] quarter_wave(input logic [4:0] k);
    logic [SampleW-1:0] v;
    case (k)
      5'd0:    v = 32'd0;
      5'd1:    v = 32'd185703302;
      5'd2:    v = 32'd369993289;
      5'd3:    v = 32'd551467404;
      5'd4:    v = 32'd728744519;
      5'd5:    v = 32'd900475449;
      5'd6:    v = 32'd1065353216;
      5'd7:    v = 32'd1222123002;
      5'd8:    v = 32'd1369591694;
      5'd9:    v = 32'd1506636967;
      5'd10:   v = 32'd1632215822;
      5'd11:   v = 32'd1745372530;
      5'd12:   v = 32'd1845245898;
      5'd13:   v = 32'd1931075831;
      5'd14:   v = 32'd2002209111;
      5'd15:   v = 32'd2058104371;
      5'd16:   v = 32'd2098336214;
      5'd17:   v = 32'd2122598451;
      5'd18:   v = 32'd2130706432;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // Full-cycle sine for an index below 72, folded onto the quarter wave.
  function automatic logic [SampleW-1:0] sine_at(input logic [PhaseW-1:0] idx);
    logic               neg;
    logic [PhaseW-1:0]  half;
    logic [PhaseW-1:0]  quad;
    logic [SampleW-1:0] mag;
    neg  = (idx >= HALF_POINTS_V);
    half = neg ? (idx - HALF_POINTS_V) : idx;
    quad = (half > QUARTER_POINTS_V) ? (HALF_POINTS_V - half) : half;
    mag  = quarter_wave(quad[4:0]);
    return neg ? (32'd0 - mag) : mag;
  endfunction

endpackage

/* hw/rtl/qpsk_front.sv */
// Input side of the QPSK generator: a four-entry symbol queue that maps
// each symbol to its phase offset. Depends on qpsk_pkg.
module qpsk_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          in_symbol,
  output qpsk_pkg::qpsk_sym_t sym,
  input  logic                sym_ready
);
  import qpsk_pkg::*;

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  logic [OffsetW-1:0] mem_r [Depth];
  logic [PtrW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PtrW:0]      cnt_r, cnt_nxt;
  logic               wr_en, rd_en;

  assign full  = (cnt_r == (PtrW+1)'(Depth));
  assign wr_en = push && !full;
  assign rd_en = sym.valid && sym_ready;

  assign sym.valid  = (cnt_r != '0);
  assign sym.offset = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (PtrW+1)'(wr_en) - (PtrW+1)'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= symbol_offset(in_symbol);
    end
  end

endmodule

/* hw/rtl/qpsk_gen.sv */
// Sample generator of the QPSK block: holds the carrier phase and the
// per-symbol sample counter, and reads the sine table. Depends on qpsk_pkg.
module qpsk_gen (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [qpsk_pkg::CountW-1:0]   spr,
  input  logic [qpsk_pkg::PhaseW-1:0]   step,
  input  qpsk_pkg::qpsk_sym_t           sym,
  output logic                          sym_ready,
  output qpsk_pkg::qpsk_beat_t          beat,
  input  logic                          beat_ready
);
  import qpsk_pkg::*;

  logic               busy_r, busy_nxt;
  logic [OffsetW-1:0] offset_r, offset_nxt;
  logic [CountW-1:0]  n_r, n_nxt;
  logic [PhaseW-1:0]  phase_r, phase_nxt;
  logic               advance;
  logic               last_c;
  logic               take;
  logic [PhaseW:0]    idx_sum;
  logic [PhaseW-1:0]  idx;
  logic [PhaseW:0]    ph_sum;

  assign last_c    = ({1'b0, n_r} + 7'd1) == {1'b0, spr};
  assign advance   = busy_r && beat_ready;
  assign sym_ready = !busy_r || (advance && last_c);
  assign take      = sym.valid && sym_ready;

  always_comb begin
    idx_sum = {1'b0, phase_r} + {2'b00, offset_r};
    idx     = (idx_sum >= {1'b0, PHASE_POINTS_V}) ?
              PhaseW'(idx_sum - {1'b0, PHASE_POINTS_V}) : idx_sum[PhaseW-1:0];
    ph_sum  = {1'b0, phase_r} + {1'b0, step};
  end

  assign beat.valid  = busy_r;
  assign beat.sample = sine_at(idx);
  assign beat.last   = last_c;

  always_comb begin
    busy_nxt   = busy_r;
    offset_nxt = offset_r;
    n_nxt      = n_r;
    phase_nxt  = phase_r;
    if (advance) begin
      phase_nxt = (ph_sum >= {1'b0, PHASE_POINTS_V}) ?
                  PhaseW'(ph_sum - {1'b0, PHASE_POINTS_V}) : ph_sum[PhaseW-1:0];
      n_nxt     = n_r + 1'b1;
      if (last_c) begin
        busy_nxt = 1'b0;
      end
    end
    if (take) begin
      // A symbol with no samples is consumed without touching the phase.
      busy_nxt   = (spr != '0);
      offset_nxt = sym.offset;
      n_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      n_r     <= '0;
      phase_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      n_r     <= n_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    offset_r <= offset_nxt;
  end

endmodule

/* hw/rtl/qpsk_outq.sv */
// Output side of the QPSK block: a two-entry result queue that keeps the
// generator running while the consumer stalls. Depends on qpsk_pkg.
module qpsk_outq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  qpsk_pkg::qpsk_beat_t           beat,
  output logic                           beat_ready,
  output logic                           empty,
  input  logic                           pop,
  output logic [qpsk_pkg::SampleW-1:0]   out_sample,
  output logic                           out_last
);
  import qpsk_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);

  logic [SampleW:0] mem_r [Depth];
  logic [PtrW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [PtrW:0]    cnt_r, cnt_nxt;
  logic             wr_en, rd_en;

  assign empty      = (cnt_r == '0);
  assign rd_en      = pop && !empty;
  assign beat_ready = (cnt_r != (PtrW+1)'(Depth)) || rd_en;
  assign wr_en      = beat.valid && beat_ready;

  assign out_sample = mem_r[rd_ptr_r][SampleW:1];
  assign out_last   = mem_r[rd_ptr_r][0];

  assign cnt_nxt = cnt_r + (PtrW+1)'(wr_en) - (PtrW+1)'(rd_en);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= {beat.sample, beat.last};
    end
  end

endmodule

/* hw/rtl/qpsk_modulator.sv */
// Top level of the QPSK carrier generator.
// Instantiates qpsk_front, qpsk_gen and qpsk_outq; depends on qpsk_pkg.
//
// Each input beat carries one two-bit symbol (first data bit in bit 1). The
// symbol selects a phase offset of 27, 9, 45 or 63 seventy-seconds of a
// carrier period, and the block then emits samples_per_symbol (30 after
// reset) signed 32-bit sine samples, the final one marked by out_last. The
// carrier phase advances by phase_step after every sample and runs on across
// symbols, so the carrier stays continuous. The generator makes one sample
// per clock cycle while the output queue has room; a symbol with a sample
// count of zero is consumed and produces nothing. Symbols wait in a
// four-entry input queue and results in a two-entry output queue, so the
// next symbol is taken while the current one is still being played out, and
// a short stall at the output does not stop the input. The first sample of
// a symbol that meets an idle block passes through the input queue, the
// generator and the output queue, each registered, on its way to the output.
// Configuration writes are meant for an idle block; register 0 is
// samples_per_symbol (low six bits of cfg_data), register 1 is phase_step
// (taken modulo 72), and other indexes are ignored.
module qpsk_modulator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      in_symbol,
  output logic                            empty,
  input  logic                            pop,
  output logic signed [qpsk_pkg::SampleW-1:0] out_sample,
  output logic                            out_last,
  input  logic                            cfg_we,
  input  logic [qpsk_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [qpsk_pkg::CfgDataW-1:0]   cfg_data
);
  import qpsk_pkg::*;

  logic [CountW-1:0]  spr_r;
  logic [PhaseW-1:0]  step_r;
  qpsk_sym_t          sym;
  logic               sym_ready;
  qpsk_beat_t         beat;
  logic               beat_ready;
  logic [SampleW-1:0] sample_w;

  // The step is stored already reduced modulo 72; a 7-bit value needs at
  // most one subtraction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spr_r  <= SPR_RESET;
      step_r <= STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SAMPLES_PER_SYMBOL: begin
          spr_r <= cfg_data[CountW-1:0];
        end
        CFG_PHASE_STEP: begin
          step_r <= (cfg_data >= PHASE_POINTS_V) ? (cfg_data - PHASE_POINTS_V) : cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // Input queue: accepts symbols and converts them to phase offsets.
  qpsk_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_symbol (in_symbol),
    .sym       (sym),
    .sym_ready (sym_ready)
  );

  // Sample generator: one sine sample per cycle while the output has room.
  qpsk_gen u_gen (
    .clk        (clk),
    .rst_n      (rst_n),
    .spr        (spr_r),
    .step       (step_r),
    .sym        (sym),
    .sym_ready  (sym_ready),
    .beat       (beat),
    .beat_ready (beat_ready)
  );

  // Result queue: decouples the generator from the consumer.
  qpsk_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat       (beat),
    .beat_ready (beat_ready),
    .empty      (empty),
    .pop        (pop),
    .out_sample (sample_w),
    .out_last   (out_last)
  );

  assign out_sample = $signed(sample_w);

endmodule

/* tb/qpsk_modulator_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the QPSK carrier generator qpsk_modulator.
// Depends on qpsk_pkg for widths and register indexes, and on the RTL alone.
module qpsk_modulator_tb;
  import qpsk_pkg::*;

  // Register indexes that the block does not implement; writes to them
  // must leave the configuration untouched.
  localparam logic [CfgIdxW-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_3 = 2'd3;

  // Settling time after the output has drained. A symbol with a sample
  // count of zero produces no beat, so the block may still be chewing on a
  // few of those; the four-entry input queue empties in well under this.
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned LongHoldCycles = 300;

  // One expected output beat.
  typedef struct {
    logic signed [SampleW-1:0] sample;
    logic                      last;
  } carrier_beat_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      push = 1'b0;
  logic                      full;
  logic [1:0]                in_symbol = 2'd0;
  logic                      empty;
  logic                      pop = 1'b0;
  logic signed [SampleW-1:0] out_sample;
  logic                      out_last;
  logic                      cfg_we = 1'b0;
  logic [CfgIdxW-1:0]        cfg_index = '0;
  logic [CfgDataW-1:0]       cfg_data = '0;

  // Sine magnitudes for 0 to 90 degrees in 5-degree steps, full scale 0x7F000000.
  logic [SampleW-1:0] quarter_mag [19] = '{
    32'd0,          32'd185703302,  32'd369993289,  32'd551467404,
    32'd728744519,  32'd900475449,  32'd1065353216, 32'd1222123002,
    32'd1369591694, 32'd1506636967, 32'd1632215822, 32'd1745372530,
    32'd1845245898, 32'd1931075831, 32'd2002209111, 32'd2058104371,
    32'd2098336214, 32'd2122598451, 32'd2130706432
  };

  // Phase offset of each constellation point, in 1/72 of a carrier period.
  logic [OffsetW-1:0] symbol_phase [4] = '{6'd27, 6'd9, 6'd45, 6'd63};

  // Shadow of the block's registers and running carrier phase.
  logic [CountW-1:0] cur_spr;
  logic [PhaseW-1:0] cur_step;
  logic [PhaseW-1:0] carrier_phase_q;

  logic [1:0]    pending_symbols [$];
  carrier_beat_t expected_samples [$];

  // Idling control: the stimulus process turns random gaps off for the last
  // part of the run and asks the sample checker for a long hold-off.
  logic idle_on = 1'b1;
  int   hold_requests = 0;
  int   holds_done = 0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   hold_left = 0;

  int errors = 0;
  int symbols_sent = 0;
  int samples_checked = 0;
  int settings_used = 1;

  qpsk_modulator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_symbol  (in_symbol),
    .empty      (empty),
    .pop        (pop),
    .out_sample (out_sample),
    .out_last   (out_last),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // Signed carrier sample for a table index below 72. The second half of
  // the cycle is the negated first half, and each half folds about 90 deg.
  function automatic logic signed [SampleW-1:0] carrier_sine(input int unsigned idx);
    int unsigned        fold;
    logic [SampleW-1:0] mag;
    fold = (idx >= HalfPoints) ? idx - HalfPoints : idx;
    if (fold > QuarterPoints) begin
      fold = HalfPoints - fold;
    end
    mag = quarter_mag[fold];
    return (idx >= HalfPoints) ? (32'd0 - mag) : mag;
  endfunction

  // Works out every beat that one accepted symbol produces and advances the
  // shadow carrier phase. A zero sample count yields nothing and leaves the
  // phase where it was.
  function automatic void expect_symbol_samples(input logic [1:0] sym);
    int unsigned   step;
    int unsigned   idx;
    carrier_beat_t beat;
    step = cur_step % PhasePoints;
    for (int unsigned n = 0; n < cur_spr; n++) begin
      idx = (carrier_phase_q + symbol_phase[sym]) % PhasePoints;
      beat.sample = carrier_sine(idx);
      beat.last = (n + 1 == cur_spr);
      expected_samples.push_back(beat);
      carrier_phase_q = PhaseW'((carrier_phase_q + step) % PhasePoints);
    end
  endfunction

  // Symbol driver. Holds push and in_symbol steady until the beat is taken,
  // then either inserts a random gap or presents the next pending symbol.
  // Every symbol is predicted at the edge where the block accepts it.
  always @(posedge clk) begin : drive_symbols
    logic       taken;
    logic       next_push;
    logic [1:0] next_sym;
    taken = push && !full;
    next_push = push;
    next_sym = in_symbol;
    if (!rst_n) begin
      next_push = 1'b0;
      gap_left = 0;
      carrier_phase_q = '0;
    end else begin
      if (taken) begin
        expect_symbol_samples(in_symbol);
        symbols_sent++;
      end
      if (!push || taken) begin
        next_push = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(1, 13) - 1;
        end else if (pending_symbols.size() != 0) begin
          next_push = 1'b1;
          next_sym = pending_symbols.pop_front();
        end
      end
    end
    push <= next_push;
    in_symbol <= next_sym;
  end

  // Sample checker. Compares each accepted beat with the oldest expected
  // one, then decides pop for the next cycle: a requested long hold-off,
  // random stall bursts, or steady draining.
  always @(posedge clk) begin : check_samples
    carrier_beat_t want;
    logic          next_pop;
    if (rst_n && pop && !empty) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got sample %0d last %0b",
                 $time, out_sample, out_last);
        errors++;
      end else begin
        want = expected_samples.pop_front();
        if (out_sample !== want.sample) begin
          $display("%0t: sample mismatch, expected %0d, got %0d",
                   $time, want.sample, out_sample);
          errors++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last mismatch, expected %0b, got %0b",
                   $time, want.last, out_last);
          errors++;
        end
        samples_checked++;
      end
    end
    next_pop = 1'b0;
    if (!rst_n) begin
      stall_left = 0;
    end else if (hold_requests != holds_done) begin
      // Long hold-off: the sender keeps going, so both queues fill and
      // the block has to push back on its input.
      holds_done++;
      hold_left = LongHoldCycles;
    end else if (hold_left > 0) begin
      hold_left--;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
    end else begin
      next_pop = 1'b1;
    end
    pop <= next_pop;
  end

  // Called at a rising edge; the write lands at the next one, where the
  // shadow registers follow it.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx == CFG_SAMPLES_PER_SYMBOL) begin
      cur_spr = data[CountW-1:0];
    end else if (idx == CFG_PHASE_STEP) begin
      cur_step = data;
    end
  endtask

  // Sender pause: waits until every symbol is taken and every expected
  // beat has come out, then lets zero-count symbols finish. Returns at a
  // rising edge.
  task automatic wait_until_drained();
    do begin
      @(negedge clk);
    end while (pending_symbols.size() != 0 || push || expected_samples.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Drains the block, writes both registers and lines up at a falling edge
  // so the caller can queue the next batch of symbols.
  task automatic reconfigure(input logic [CfgDataW-1:0] spr_data,
                             input logic [CfgDataW-1:0] step_data);
    wait_until_drained();
    write_reg(CFG_SAMPLES_PER_SYMBOL, spr_data);
    write_reg(CFG_PHASE_STEP, step_data);
    cfg_we <= 1'b0;
    settings_used++;
    @(negedge clk);
  endtask

  // One random batch: a random setting, biased toward short symbols, with
  // now and then zero, the maximum or a long count. Bit 6 of the count
  // write is junk that the block must drop.
  task automatic random_batch(input int n_symbols, input int min_spr);
    int          pick;
    logic [5:0]  spr;
    logic [6:0]  step;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       spr = 6'd0;
      1:       spr = 6'd63;
      2:       spr = 6'($urandom_range(32, 62));
      default: spr = 6'($urandom_range(1, 12));
    endcase
    if (spr < min_spr) begin
      spr = 6'(min_spr);
    end
    step = 7'($urandom_range(0, 127));
    reconfigure({1'($urandom_range(0, 1)), spr}, step);
    repeat (n_symbols) pending_symbols.push_back(2'($urandom_range(0, 3)));
  endtask

  initial begin : stimulus
    cur_spr = SPR_RESET;
    cur_step = STEP_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset setting, 30 samples and step 4: all four points, carrier
    // continuity between symbols.
    pending_symbols = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd3, 2'd0};

    // One sample per symbol with a frozen carrier: each beat is last and the
    // point's own offset shows directly.
    reconfigure(7'd1, 7'd0);
    pending_symbols = '{2'd0, 2'd1, 2'd2, 2'd3};

    // Longest symbols and the largest in-range step.
    reconfigure(7'd63, 7'd71);
    pending_symbols = '{2'd3, 2'd0};

    // Zero samples per symbol, written with the unused top bit set; an
    // out-of-range step; and junk written to the unimplemented indexes.
    // These symbols produce nothing and must not move the carrier.
    wait_until_drained();
    write_reg(CFG_SAMPLES_PER_SYMBOL, 7'h40);
    write_reg(CFG_PHASE_STEP, 7'd127);
    write_reg(CFG_SPARE_2, 7'h7F);
    write_reg(CFG_SPARE_3, 7'h2A);
    cfg_we <= 1'b0;
    settings_used++;
    @(negedge clk);
    pending_symbols = '{2'd1, 2'd2, 2'd3};

    // A step of exactly 72 wraps to a standing carrier.
    reconfigure(7'd5, 7'd72);
    pending_symbols = '{2'd2, 2'd1};

    // Back to the largest step, reduced modulo 72 to 55.
    reconfigure(7'd7, 7'd127);
    pending_symbols = '{2'd0, 2'd3, 2'd1};

    // Random part. The first batch also holds the output off for a long
    // stretch while symbols keep arriving.
    random_batch(32, 2);
    hold_requests++;
    repeat (4) random_batch(32, 0);

    // Last batch runs flat out on both sides.
    idle_on = 1'b0;
    random_batch(32, 1);

    wait_until_drained();
    repeat (SettleCycles) @(posedge clk);
    $display("Run summary: %0d symbols, %0d beats checked, %0d register settings.",
             symbols_sent, samples_checked, settings_used);
    $display("Included zero-length symbols, wrapped steps, spare indexes and a long hold-off.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Safety net: far beyond the slowest legal run.
  initial begin : watchdog
    #20_000_000;
    $display("%0t: timeout, %0d beats still expected", $time, expected_samples.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
